/* rtl/dhar_pkg.sv */
// Shared constants and types for the auto-range displacement histogram.
`timescale 1ns / 1ps

package dhar_pkg;

  localparam int MaxSamples = 4096;
  localparam int MaxBins    = 63;
  localparam int AddrW      = $clog2(MaxSamples);
  localparam int FillW      = $clog2(MaxSamples + 1);
  localparam int BinW       = 6;
  localparam int CntW       = 13;
  localparam int DataW      = 32;
  localparam int DivW       = 33;

  localparam logic [CntW-1:0] CntSat = 13'd8191;

  localparam logic CfgBinNumber   = 1'b0;
  localparam logic CfgSubtractCom = 1'b1;

  // Request to the serial divider.
  typedef struct packed {
    logic            start;
    logic [63:0]     dividend;
    logic [DivW-1:0] divisor;
  } div_req_t;

  // Result of the serial divider.
  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

endpackage

/* rtl/dhar_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module dhar_div
  import dhar_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [63:0]     quo_r, quo_nxt;
  logic [DivW-1:0] rem_r, rem_nxt;
  logic [DivW-1:0] dvs_r, dvs_nxt;
  logic [6:0]      cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [DivW:0]   trial;
  logic [DivW:0]   shifted;

  // Shift one dividend bit into the remainder and try a subtract.
  always_comb begin
    shifted  = {rem_r, quo_r[63]};
    trial    = shifted - {1'b0, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[DivW]) begin
        rem_nxt = trial[DivW-1:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = shifted[DivW-1:0];
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

/* rtl/displacement_histogram_auto_range.sv */
// Top level: sample store, min/max tracking, binning sequencer, result output.
//
//   channel | ports              | handshake
//   --------+--------------------+----------------------
//   input   | in_*               | in_valid / in_ready
//   result  | out_*              | out_valid / out_ready
//   config  | cfg_*              | cfg_we, no wait
//
// Load: one item per cycle while no run is being binned.
// Binning: clear the counts, divide the range by N for the bin width, then for
// each stored sample a 64-step serial divide plus read and count update (no
// divide when the range is zero), then a setup step for the result output.
// Results go out one per cycle while out_ready is high; low edges are a running add.
// Reset is synchronous; the sample store is not cleared (only filled entries are read).
// A stalled result holds the sequencer; the input is not taken until all bins leave.
`timescale 1ns / 1ps

module displacement_histogram_auto_range
  import dhar_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [DataW-1:0] in_pos_now,
  input  logic signed [DataW-1:0] in_pos_start,
  input  logic signed [DataW-1:0] in_com_now,
  input  logic signed [DataW-1:0] in_com_start,
  input  logic                    in_final_sample,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [BinW-1:0]         out_bin_index,
  output logic [CntW-1:0]         out_bin_count,
  output logic signed [DataW-1:0] out_bin_low_edge,
  output logic [DataW-1:0]        out_bin_width,
  output logic [CntW-1:0]         out_sample_total,
  output logic                    out_samples_dropped,
  output logic                    out_last_bin,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [BinW-1:0]         cfg_wdata
);

  typedef enum logic [3:0] {
    S_LOAD, S_CLEAR, S_WDIV, S_WWAIT, S_RD, S_RDW, S_SDIV, S_SWAIT, S_CRD, S_CINC,
    S_EMIT, S_OUT
  } state_t;

  state_t state_r;

  logic [BinW-1:0]         bin_number_r;
  logic                    subtract_com_r;
  logic [FillW-1:0]        fill_r;
  logic signed [DataW-1:0] min_r, max_r;
  logic                    ovf_r;
  logic [CntW-1:0]         counts_r [MaxBins+1];
  logic [DataW-1:0]        store [MaxSamples];
  logic signed [DataW-1:0] rd_r;
  logic [AddrW-1:0]        k_r;
  logic [BinW-1:0]         n_r, i_r;
  logic [BinW-1:0]         bin_r;
  logic [CntW-1:0]         cnt_rd_r;
  logic [DivW-1:0]         range_r;
  logic [DataW-1:0]        width_r;
  logic signed [DataW+1:0] edge_r;
  div_req_t                req;
  div_rsp_t                rsp;

  // Displacement, saturated to 32 bits.
  logic signed [DataW+1:0] d_ext;
  logic signed [DataW-1:0] d_sat;
  always_comb begin
    d_ext = (DataW+2)'(in_pos_now) - (DataW+2)'(in_pos_start);
    if (subtract_com_r)
      d_ext = d_ext - ((DataW+2)'(in_com_now) - (DataW+2)'(in_com_start));
    if (d_ext > (DataW+2)'(34'sh07FFFFFFF))      d_sat = 32'sh7FFFFFFF;
    else if (d_ext < -(DataW+2)'(34'sh080000000)) d_sat = 32'sh80000000;
    else                                          d_sat = d_ext[DataW-1:0];
  end

  logic accept, store_ok;
  assign in_ready = (state_r == S_LOAD);
  assign accept   = in_valid && in_ready;
  assign store_ok = (fill_r < FillW'(MaxSamples));

  // Effective N and range at the end of loading.
  logic [BinW-1:0] n_eff;
  always_comb begin
    n_eff = bin_number_r;
    if (n_eff == '0) n_eff = BinW'(1);
    if (n_eff > BinW'(MaxBins)) n_eff = BinW'(MaxBins);
  end

  logic signed [DataW-1:0] mn_fin, mx_fin;
  always_comb begin
    mn_fin = min_r;
    mx_fin = max_r;
    if (accept && store_ok) begin
      if (d_sat < mn_fin) mn_fin = d_sat;
      if (d_sat > mx_fin) mx_fin = d_sat;
    end
  end

  // Sample offset times N for the divider.
  logic [DivW-1:0] off;
  assign off = DivW'($signed({rd_r[DataW-1], rd_r}) - $signed({min_r[DataW-1], min_r}));

  always_comb begin
    req = '0;
    if (state_r == S_WDIV) begin
      req.start    = 1'b1;
      req.dividend = 64'(range_r);
      req.divisor  = DivW'(n_r);
    end else if (state_r == S_SDIV) begin
      req.start    = 1'b1;
      req.dividend = 64'(off) * 64'(n_r);
      req.divisor  = range_r;
    end
  end

  dhar_div u_div (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  // Store write and registered read.
  always_ff @(posedge clk) begin
    if (accept && store_ok) store[fill_r[AddrW-1:0]] <= d_sat;
    if (state_r == S_RD) rd_r <= store[k_r];
  end

  logic [BinW-1:0] bsel;
  always_comb begin
    bsel = (rsp.quotient > 64'(n_r)) ? n_r : rsp.quotient[BinW-1:0];
  end

  logic signed [DataW+1:0] edge_sat_in;
  assign edge_sat_in = edge_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_LOAD;
      bin_number_r   <= BinW'(32);
      subtract_com_r <= 1'b0;
      fill_r         <= '0;
      min_r          <= 32'sh7FFFFFFF;
      max_r          <= 32'sh80000000;
      ovf_r          <= 1'b0;
      out_valid      <= 1'b0;
      k_r            <= '0;
      i_r            <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CfgBinNumber:   bin_number_r   <= cfg_wdata;
          CfgSubtractCom: subtract_com_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      case (state_r)
        S_LOAD: begin
          if (accept) begin
            if (store_ok) fill_r <= fill_r + FillW'(1);
            else ovf_r <= 1'b1;
            min_r <= mn_fin;
            max_r <= mx_fin;
            if (in_final_sample) begin
              n_r     <= n_eff;
              range_r <= DivW'($signed({mx_fin[DataW-1], mx_fin})
                               - $signed({mn_fin[DataW-1], mn_fin}));
              i_r     <= '0;
              state_r <= S_CLEAR;
            end
          end
        end
        // Clear the counts one bin a cycle.
        S_CLEAR: begin
          counts_r[i_r] <= '0;
          i_r <= i_r + BinW'(1);
          if (i_r == BinW'(MaxBins)) state_r <= S_WDIV;
        end
        S_WDIV: state_r <= S_WWAIT;
        S_WWAIT: begin
          if (rsp.done) begin
            width_r <= rsp.quotient[DataW-1:0];
            k_r     <= '0;
            state_r <= (fill_r == '0) ? S_EMIT : S_RD;
          end
        end
        S_RD:  state_r <= S_RDW;
        S_RDW: state_r <= (range_r == '0) ? S_SWAIT : S_SDIV;
        S_SDIV: state_r <= S_SWAIT;
        S_SWAIT: begin
          if (range_r == '0 || rsp.done) begin
            bin_r   <= (range_r == '0) ? '0 : bsel;
            state_r <= S_CRD;
          end
        end
        // Read-modify-write of the selected bin count.
        S_CRD: begin
          cnt_rd_r <= counts_r[bin_r];
          state_r  <= S_CINC;
        end
        S_CINC: begin
          if (cnt_rd_r != CntSat) counts_r[bin_r] <= cnt_rd_r + CntW'(1);
          if (FillW'(k_r) + FillW'(1) == fill_r) state_r <= S_EMIT;
          else begin
            k_r     <= k_r + AddrW'(1);
            state_r <= S_RD;
          end
        end
        S_EMIT: begin
          edge_r  <= (fill_r == '0) ? '0 : (DataW+2)'(min_r);
          i_r     <= '0;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            if (out_valid && out_last_bin) begin
              out_valid <= 1'b0;
              fill_r    <= '0;
              min_r     <= 32'sh7FFFFFFF;
              max_r     <= 32'sh80000000;
              ovf_r     <= 1'b0;
              state_r   <= S_LOAD;
            end else begin
              out_valid        <= 1'b1;
              out_bin_index    <= i_r;
              out_bin_count    <= counts_r[i_r];
              if (edge_sat_in > (DataW+2)'(34'sh07FFFFFFF))
                out_bin_low_edge <= 32'sh7FFFFFFF;
              else
                out_bin_low_edge <= edge_sat_in[DataW-1:0];
              out_bin_width    <= width_r;
              out_sample_total <= (fill_r > FillW'(CntSat)) ? CntSat : CntW'(fill_r);
              out_samples_dropped <= ovf_r;
              out_last_bin     <= (i_r == n_r);
              edge_r           <= edge_r + (DataW+2)'({2'b00, width_r});
              i_r              <= i_r + BinW'(1);
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

endmodule
